[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the outlier threshold filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define AOTF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define AOTF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/aotf_pkg.sv]
// Package with widths, reset values and register indexes of the outlier threshold filter.
`default_nettype none
package aotf_pkg;
	localparam int DIST_BITS = 24;
	localparam int REG_BITS = 24;
	localparam int CNT_BITS = 17;
	localparam int SUM_BITS = 40;
	localparam int SQ_BITS = 64;
	localparam int PROD_BITS = 2 * DIST_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CNT_BITS-1:0] MAX_SAMPLES = 17'd65536;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	localparam logic [REG_BITS-1:0] GOOD_DIST_RST = 24'd4096;
	localparam logic [REG_BITS-1:0] FALLBACK_RST = 24'hFFFFFF;
	localparam logic [REG_BITS-1:0] INIT_THR_RST = 24'hFFFFFF;

	localparam logic [CFG_IDX_BITS-1:0] CFG_GOOD_DIST = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FALLBACK = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_THR = 2'd2;
endpackage
`default_nettype wire

[rtl/aotf_in_if.sv]
// Input channel carrying one distance word per handshake.
`default_nettype none
interface aotf_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [aotf_pkg::DIST_BITS-1:0] distance;
	logic last;

	modport source(output valid, output mode, output distance, output last, input ready);
	modport sink(input valid, input mode, input distance, input last, output ready);
endinterface
`default_nettype wire

[rtl/aotf_out_if.sv]
// Result channel carrying one result word per handshake.
`default_nettype none
interface aotf_out_if;
	logic valid;
	logic ready;
	logic kept;
	logic [aotf_pkg::REG_BITS-1:0] threshold;
	logic [aotf_pkg::REG_BITS-1:0] mean_dist;
	logic [aotf_pkg::REG_BITS-1:0] std_dev;
	logic [aotf_pkg::CNT_BITS-1:0] outlier_count;
	logic final_res;

	modport source(output valid, output kept, output threshold, output mean_dist,
		output std_dev, output outlier_count, output final_res, input ready);
	modport sink(input valid, input kept, input threshold, input mean_dist,
		input std_dev, input outlier_count, input final_res, output ready);
endinterface
`default_nettype wire

[rtl/adaptive_outlier_threshold_filter.sv]
// Top level: two-pass adaptive outlier threshold filter with a shared divide/root step unit.
// Statistics word that is not last: accepted in IDLE, squared in SQ, accumulated in ACC, then ready again.
// Last statistics word: states DSET, DIVM, DIVS, MSQR, VAR, SQRT, FIN (DSET goes to FIN if no distance survived);
// two 64-step divisions and a 24-step square root run one bit per cycle through the shared subtractor.
// Classification word: accepted in IDLE, compared in FIN; a result may wait in the output register.
// Reset (arst_n low) clears control and counters and loads registers with their defaults.
`default_nettype none
`include "assert_macros.svh"
module adaptive_outlier_threshold_filter (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [aotf_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  wire logic [aotf_pkg::REG_BITS-1:0] cfg_data,
	aotf_in_if.sink in_ch,
	aotf_out_if.source out_ch
);
	localparam int DB = aotf_pkg::DIST_BITS;
	localparam int CB = aotf_pkg::CNT_BITS;
	localparam int PB = aotf_pkg::PROD_BITS;
	localparam int SUBW = 28;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SQ   = 10'b0000000010,
		ST_ACC  = 10'b0000000100,
		ST_DSET = 10'b0000001000,
		ST_DIVM = 10'b0000010000,
		ST_DIVS = 10'b0000100000,
		ST_MSQR = 10'b0001000000,
		ST_VAR  = 10'b0010000000,
		ST_SQRT = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic cls_q;

	logic [aotf_pkg::REG_BITS-1:0] good_q, fallback_q;
	logic [DB-1:0] prev_thr_q, new_thr_q;
	logic [aotf_pkg::SUM_BITS-1:0] dist_sum_q;
	logic [aotf_pkg::SQ_BITS-1:0] sq_sum_q;
	logic [CB-1:0] surv_cnt_q, sample_cnt_q, inlier_cnt_q;

	logic [DB-1:0] d_q;
	logic mode_q, last_q, surv_q;
	logic [PB-1:0] prod_q;
	logic [DB-1:0] mean_q;
	logic [PB-1:0] msq_q;
	logic [aotf_pkg::SQ_BITS-1:0] quo_q;
	logic [25:0] rem_q;
	logic [DB-1:0] root_q;
	logic [5:0] step_q;

	logic out_valid_q, out_kept_q, out_final_q;
	logic [aotf_pkg::REG_BITS-1:0] out_thr_q, out_mean_q, out_sd_q;
	logic [CB-1:0] out_outl_q;

	function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] c);
		inc_sat = (c < aotf_pkg::MAX_SAMPLES) ? c + 1'b1 : c;
	endfunction

	// Shared multiplier: distance squared per word, mean squared once per pass end.
	logic [DB-1:0] mul_a;
	logic [PB-1:0] mul_p;
	assign mul_a = (state_q == ST_SQ) ? d_q : mean_q;
	assign mul_p = mul_a * mul_a;

	// Shared trial subtractor for the restoring divider and the digit-by-digit root.
	logic [SUBW-1:0] sub_a, sub_b;
	logic [SUBW:0] sub_d;
	logic sub_ge;
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q, quo_q[63:62]};
			sub_b = {2'b00, root_q, 2'b01};
		end else begin
			sub_a = {10'd0, rem_q[CB-1:0], quo_q[63]};
			sub_b = {{(SUBW-CB){1'b0}}, surv_cnt_q};
		end
	end
	assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_d[SUBW];

	logic [aotf_pkg::SQ_BITS-1:0] quo_div_nxt;
	logic [CB-1:0] rem_div_nxt;
	assign quo_div_nxt = {quo_q[62:0], sub_ge};
	assign rem_div_nxt = sub_ge ? sub_d[CB-1:0] : sub_a[CB-1:0];

	logic [PB-1:0] var_w;
	assign var_w = (msq_q > prod_q) ? msq_q - prod_q : '0;

	// Threshold selection from mean and standard deviation.
	logic [25:0] sd3, good3;
	logic [26:0] good6, thr_raw;
	logic [DB-1:0] thr_sat;
	always_comb begin
		sd3 = {2'b00, root_q} + {1'b0, root_q, 1'b0};
		good3 = {2'b00, good_q} + {1'b0, good_q, 1'b0};
		good6 = {good3, 1'b0};
		if (surv_cnt_q == '0) begin
			thr_raw = {3'd0, fallback_q};
		end else if (mean_q < good_q) begin
			thr_raw = {3'd0, mean_q} + {1'b0, sd3};
		end else if ({2'b00, mean_q} < good3) begin
			thr_raw = {3'd0, mean_q} + {2'b00, root_q, 1'b0};
		end else if ({3'd0, mean_q} < good6) begin
			thr_raw = {3'd0, mean_q} + {3'd0, root_q};
		end else begin
			thr_raw = {3'd0, fallback_q};
		end
		thr_sat = (thr_raw > {3'd0, aotf_pkg::DIST_MAX}) ? aotf_pkg::DIST_MAX : thr_raw[DB-1:0];
	end

	// Classification of the held word.
	logic kept_w;
	logic [CB-1:0] inl_nxt, outl_w;
	assign kept_w = (d_q <= prev_thr_q) && (d_q <= new_thr_q);
	assign inl_nxt = kept_w ? inc_sat(inlier_cnt_q) : inlier_cnt_q;
	assign outl_w = (sample_cnt_q >= inl_nxt) ? sample_cnt_q - inl_nxt : '0;

	logic slot_free, res_load;
	assign slot_free = !out_valid_q || out_ch.ready;
	assign res_load = (state_q == ST_FIN) && slot_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.kept = out_kept_q;
	assign out_ch.threshold = out_thr_q;
	assign out_ch.mean_dist = out_mean_q;
	assign out_ch.std_dev = out_sd_q;
	assign out_ch.outlier_count = out_outl_q;
	assign out_ch.final_res = out_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cls_q <= 1'b0;
			good_q <= aotf_pkg::GOOD_DIST_RST;
			fallback_q <= aotf_pkg::FALLBACK_RST;
			prev_thr_q <= aotf_pkg::INIT_THR_RST;
			new_thr_q <= aotf_pkg::INIT_THR_RST;
			dist_sum_q <= '0;
			sq_sum_q <= '0;
			surv_cnt_q <= '0;
			sample_cnt_q <= '0;
			inlier_cnt_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					aotf_pkg::CFG_GOOD_DIST: good_q <= cfg_data;
					aotf_pkg::CFG_FALLBACK: fallback_q <= cfg_data;
					aotf_pkg::CFG_INIT_THR: begin
						prev_thr_q <= cfg_data;
						new_thr_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cls_q <= in_ch.mode;
						state_q <= in_ch.mode ? ST_FIN : ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_ACC;
				ST_ACC: begin
					sample_cnt_q <= inc_sat(sample_cnt_q);
					if (surv_q) begin
						surv_cnt_q <= surv_cnt_q + 1'b1;
						dist_sum_q <= dist_sum_q + {{(aotf_pkg::SUM_BITS-DB){1'b0}}, d_q};
						sq_sum_q <= sq_sum_q + {{(aotf_pkg::SQ_BITS-PB){1'b0}}, prod_q};
					end
					state_q <= last_q ? ST_DSET : ST_IDLE;
				end
				ST_DSET: begin
					step_q <= '0;
					state_q <= (surv_cnt_q == '0) ? ST_FIN : ST_DIVM;
				end
				ST_DIVM: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd63) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd63) begin
						state_q <= ST_MSQR;
					end
				end
				ST_MSQR: state_q <= ST_VAR;
				ST_VAR: begin
					step_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'(DB - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (cls_q) begin
							inlier_cnt_q <= last_q ? '0 : inl_nxt;
							if (last_q) begin
								prev_thr_q <= new_thr_q;
								sample_cnt_q <= '0;
							end
						end else begin
							new_thr_q <= thr_sat;
							dist_sum_q <= '0;
							sq_sum_q <= '0;
							surv_cnt_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				d_q <= in_ch.distance;
				mode_q <= in_ch.mode;
				last_q <= in_ch.last;
			end
			ST_SQ: begin
				prod_q <= mul_p;
				surv_q <= (d_q <= prev_thr_q) && (surv_cnt_q < aotf_pkg::MAX_SAMPLES);
			end
			ST_DSET: begin
				quo_q <= {{(aotf_pkg::SQ_BITS-aotf_pkg::SUM_BITS){1'b0}}, dist_sum_q};
				rem_q <= '0;
				mean_q <= '0;
				root_q <= '0;
			end
			ST_DIVM: begin
				if (step_q == 6'd63) begin
					mean_q <= quo_div_nxt[DB-1:0];
					quo_q <= sq_sum_q;
					rem_q <= '0;
				end else begin
					quo_q <= quo_div_nxt;
					rem_q <= {9'd0, rem_div_nxt};
				end
			end
			ST_DIVS: begin
				quo_q <= quo_div_nxt;
				rem_q <= {9'd0, rem_div_nxt};
				if (step_q == 6'd63) begin
					msq_q <= quo_div_nxt[PB-1:0];
				end
			end
			ST_MSQR: prod_q <= mul_p;
			ST_VAR: begin
				quo_q <= {var_w, {(aotf_pkg::SQ_BITS-PB){1'b0}}};
				rem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				quo_q <= {quo_q[61:0], 2'b00};
				rem_q <= sub_ge ? sub_d[25:0] : sub_a[25:0];
				root_q <= {root_q[DB-2:0], sub_ge};
			end
			ST_FIN: begin
				if (slot_free) begin
					if (mode_q) begin
						out_kept_q <= kept_w;
						out_thr_q <= new_thr_q;
						out_mean_q <= '0;
						out_sd_q <= '0;
						out_outl_q <= last_q ? outl_w : '0;
						out_final_q <= last_q;
					end else begin
						out_kept_q <= 1'b0;
						out_thr_q <= thr_sat;
						out_mean_q <= mean_q;
						out_sd_q <= root_q;
						out_outl_q <= '0;
						out_final_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	`AOTF_ASSERT(a_cnt_limit, sample_cnt_q <= aotf_pkg::MAX_SAMPLES, "sample count overran its limit")
	`AOTF_ASSERT_IMPL(a_div_rem, state_q == ST_DIVM || state_q == ST_DIVS, rem_q[CB-1:0] < surv_cnt_q, "divider remainder not below divisor")
	`AOTF_ASSERT_IMPL(a_root_rem, state_q == ST_SQRT, rem_q <= {1'b0, root_q, 1'b0}, "root remainder above twice the partial root")
	`AOTF_ASSERT(a_res_src, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result word raised outside the finish step")
endmodule
`default_nettype wire
